FILE: hw/rtl/xsp_pkg.sv
// xsp_pkg: shared types, constants and helpers for the xor schedule packet engine
// used by xor_schedule_packet_engine and xsp_checker; depends on nothing else
package xsp_pkg;

    // store geometry
    localparam int DATA_DRIVES       = 8;
    localparam int PARITY_DRIVES     = 8;
    localparam int PACKETS_PER_DRIVE = 8;
    localparam int INTER_PACKETS     = 64;
    localparam int PACKET_WORDS      = 16;

    localparam int DATA_PACKETS   = DATA_DRIVES * PACKETS_PER_DRIVE;
    localparam int PARITY_PACKETS = PARITY_DRIVES * PACKETS_PER_DRIVE;
    localparam int DATA_DEPTH     = DATA_PACKETS * PACKET_WORDS;
    localparam int PARITY_DEPTH   = PARITY_PACKETS * PACKET_WORDS;
    localparam int INTER_DEPTH    = INTER_PACKETS * PACKET_WORDS;

    localparam int DATA_AW   = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int PARITY_AW = (PARITY_DEPTH > 1) ? $clog2(PARITY_DEPTH) : 1;
    localparam int INTER_AW  = (INTER_DEPTH > 1) ? $clog2(INTER_DEPTH) : 1;
    localparam int WORD_W    = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;

    // field widths
    localparam int CMD_W    = 2;
    localparam int OP_W     = 3;
    localparam int PKT_W    = 6;
    localparam int OFS_W    = 4;
    localparam int DATA_W   = 64;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // schedule operations
    localparam logic [OP_W-1:0] OP_COPY_D2P = 3'd0;
    localparam logic [OP_W-1:0] OP_XOR_D2P  = 3'd1;
    localparam logic [OP_W-1:0] OP_COPY_I2P = 3'd2;
    localparam logic [OP_W-1:0] OP_XOR_I2P  = 3'd3;
    localparam logic [OP_W-1:0] OP_COPY_D2I = 3'd4;
    localparam logic [OP_W-1:0] OP_XOR_D2I  = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [OP_W-1:0]   op_code;
        logic [PKT_W-1:0]  src_packet;
        logic [PKT_W-1:0]  dst_packet;
        logic [OFS_W-1:0]  word_offset;
        logic [DATA_W-1:0] word_value;
    } t_in_word;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [CMD_W-1:0]  done_kind;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_DRAIN,
        S_RDWAIT
    } t_state;

    // source is the intermediate store
    function automatic logic src_is_inter(input logic [OP_W-1:0] op);
        return (op == OP_COPY_I2P) || (op == OP_XOR_I2P);
    endfunction

    // destination is the parity store
    function automatic logic dst_is_parity(input logic [OP_W-1:0] op);
        return op <= OP_XOR_I2P;
    endfunction

endpackage

FILE: hw/rtl/xsp_ram.sv
// xsp_ram: generic single-write, single-read RAM with registered read data
// standalone, no package dependency
module xsp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/xor_schedule_packet_engine.sv
// Packet engine for an XOR-scheduled erasure code: data, parity and intermediate
// packet stores, one schedule operation per word. A schedule operation (command 1
// with a valid op code and packets in range) streams the source packet through one
// shared copy/xor datapath, one 64-bit word per cycle, issuing one read per word
// into the registered-read stores in S_MOVE and then writing the last word in
// S_DRAIN; the next word is accepted once the result is posted. A parity read
// waits in S_RDWAIT for the registered store read. A data load, an ignored
// command and a no-op operation post their result in the next cycle. The stores
// come up with undefined contents; no clearing pass is run. An output register
// holds the result word, so a new word can be taken in the cycle the result leaves.
// depends on xsp_pkg and xsp_ram
module xor_schedule_packet_engine
    import xsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    // control state
    t_state             r_state, n_state;
    logic [WORD_W-1:0]  r_word, n_word;
    logic               r_wr_pend, n_wr_pend;
    logic [WORD_W-1:0]  r_wr_word, n_wr_word;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    // latched operation
    logic [PKT_W-1:0]   r_src;
    logic [PKT_W-1:0]   r_dst;
    logic               r_xor;
    logic               r_src_inter;
    logic               r_dst_par;

    logic               accept;
    logic               wo_ok;
    logic               in_ld_ok;
    logic               in_rd_ok;
    logic               in_op_ok;
    int                 src_lim;
    int                 dst_lim;
    logic               last_word;

    logic [DATA_AW-1:0]   data_waddr, data_raddr;
    logic [PARITY_AW-1:0] par_waddr, par_raddr, par_in_addr, par_dst_addr;
    logic [INTER_AW-1:0]  int_waddr, int_raddr, int_src_addr, int_dst_addr;
    logic                 data_we, par_we, int_we;
    logic [DATA_W-1:0]    data_q, par_q, int_q;
    logic [DATA_W-1:0]    src_q, dst_q, wr_data;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    // input word decode
    always_comb begin
        src_lim  = src_is_inter(i_in_data.op_code) ? INTER_PACKETS : DATA_PACKETS;
        dst_lim  = dst_is_parity(i_in_data.op_code) ? PARITY_PACKETS : INTER_PACKETS;
        wo_ok    = int'(i_in_data.word_offset) < PACKET_WORDS;
        in_ld_ok = (i_in_data.command == CMD_LOAD) && wo_ok
                   && (int'(i_in_data.dst_packet) < DATA_PACKETS);
        in_rd_ok = (i_in_data.command == CMD_READ) && wo_ok
                   && (int'(i_in_data.dst_packet) < PARITY_PACKETS);
        in_op_ok = (i_in_data.command == CMD_RUN) && (i_in_data.op_code <= OP_XOR_D2I)
                   && (int'(i_in_data.src_packet) < src_lim)
                   && (int'(i_in_data.dst_packet) < dst_lim);
    end

    assign last_word = (r_word == WORD_W'(PACKET_WORDS - 1));

    // sequencer next state and result
    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_wr_pend   = 1'b0;
        n_wr_word   = r_wr_word;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_op_ok) begin
                        n_state = S_MOVE;
                        n_word  = '0;
                    end else if (in_rd_ok) begin
                        n_state = S_RDWAIT;
                    end else begin
                        n_out_valid       = 1'b1;
                        n_out.read_value  = '0;
                        n_out.done_kind   = i_in_data.command;
                    end
                end
            end
            S_MOVE: begin
                n_wr_pend = 1'b1;
                n_wr_word = r_word;
                if (last_word) begin
                    n_state = S_DRAIN;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state          = S_IDLE;
                n_out_valid      = 1'b1;
                n_out.read_value = '0;
                n_out.done_kind  = CMD_RUN;
            end
            S_RDWAIT: begin
                n_state          = S_IDLE;
                n_out_valid      = 1'b1;
                n_out.read_value = par_q;
                n_out.done_kind  = CMD_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_word      <= '0;
            r_wr_pend   <= 1'b0;
            r_wr_word   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_wr_pend   <= n_wr_pend;
            r_wr_word   <= n_wr_word;
            r_out_valid <= n_out_valid;
        end
    end

    // result and operation payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_src       <= i_in_data.src_packet;
            r_dst       <= i_in_data.dst_packet;
            r_xor       <= i_in_data.op_code[0];
            r_src_inter <= src_is_inter(i_in_data.op_code);
            r_dst_par   <= dst_is_parity(i_in_data.op_code);
        end
    end

    // word addresses
    always_comb begin
        data_waddr   = DATA_AW'(int'(i_in_data.dst_packet) * PACKET_WORDS
                                + int'(i_in_data.word_offset));
        data_raddr   = DATA_AW'(int'(r_src) * PACKET_WORDS + int'(r_word));
        par_in_addr  = PARITY_AW'(int'(i_in_data.dst_packet) * PACKET_WORDS
                                  + int'(i_in_data.word_offset));
        par_dst_addr = PARITY_AW'(int'(r_dst) * PACKET_WORDS + int'(r_word));
        par_raddr    = (r_state == S_IDLE) ? par_in_addr : par_dst_addr;
        par_waddr    = PARITY_AW'(int'(r_dst) * PACKET_WORDS + int'(r_wr_word));
        int_src_addr = INTER_AW'(int'(r_src) * PACKET_WORDS + int'(r_word));
        int_dst_addr = INTER_AW'(int'(r_dst) * PACKET_WORDS + int'(r_word));
        int_raddr    = r_src_inter ? int_src_addr : int_dst_addr;
        int_waddr    = INTER_AW'(int'(r_dst) * PACKET_WORDS + int'(r_wr_word));
    end

    // shared copy/xor datapath
    always_comb begin
        src_q   = r_src_inter ? int_q : data_q;
        dst_q   = r_dst_par ? par_q : int_q;
        wr_data = r_xor ? (src_q ^ dst_q) : src_q;
        data_we = accept && in_ld_ok;
        par_we  = r_wr_pend && r_dst_par;
        int_we  = r_wr_pend && !r_dst_par;
    end

    xsp_ram #(.WIDTH(DATA_W), .DEPTH(DATA_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (i_in_data.word_value),
        .i_raddr (data_raddr),
        .o_rdata (data_q)
    );

    xsp_ram #(.WIDTH(DATA_W), .DEPTH(PARITY_DEPTH)) u_parity_ram (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (wr_data),
        .i_raddr (par_raddr),
        .o_rdata (par_q)
    );

    xsp_ram #(.WIDTH(DATA_W), .DEPTH(INTER_DEPTH)) u_inter_ram (
        .i_clk   (i_clk),
        .i_we    (int_we),
        .i_waddr (int_waddr),
        .i_wdata (wr_data),
        .i_raddr (int_raddr),
        .o_rdata (int_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/xsp_checker.sv
// xsp_checker: port-level assertions for xor_schedule_packet_engine, bound to it
// depends on xsp_pkg
module xsp_checker
    import xsp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // no new word while a result is blocked
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input open while result blocked");

    // a load completes in the next cycle
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.command == CMD_LOAD)
        |=> o_out_valid && (o_out_data.done_kind == CMD_LOAD))
        else $error("load result missing");

    // an accepted word either answers at once or keeps the input closed
    a_busy_or_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid || o_in_stall)
        else $error("word accepted but engine idle with no result");

    // only reads return data
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.done_kind != CMD_READ) |-> o_out_data.read_value == '0)
        else $error("nonzero value on non-read result");

endmodule

bind xor_schedule_packet_engine xsp_checker u_xsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: dv/testbench.sv
// testbench for xor_schedule_packet_engine: table-driven directed words, then random
// load / schedule / read traffic checked against a local store predictor
// depends on xsp_pkg and the engine rtl only
module testbench
    import xsp_pkg::*;
();

    // command and op codes that the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [OP_W-1:0]  OP_NOP_6   = 3'd6;
    localparam logic [OP_W-1:0]  OP_NOP_7   = 3'd7;

    localparam int RANDOM_WORDS = 520;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;

    typedef enum int {
        ST_DATA,
        ST_PARITY,
        ST_INTER
    } t_store;

    typedef struct {
        bit                fill;
        logic [CMD_W-1:0]  cmd;
        logic [OP_W-1:0]   op;
        logic [PKT_W-1:0]  src;
        logic [PKT_W-1:0]  dst;
        logic [OFS_W-1:0]  ofs;
        logic [DATA_W-1:0] val;
        bit                typed;
        logic [DATA_W-1:0] want_val;
    } t_dir_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_data;

    // predictor state: store contents and which words hold a written value
    logic [DATA_W-1:0] data_mem   [DATA_DEPTH];
    logic [DATA_W-1:0] parity_mem [PARITY_DEPTH];
    logic [DATA_W-1:0] inter_mem  [INTER_DEPTH];
    bit                data_set   [DATA_DEPTH];
    bit                parity_set [PARITY_DEPTH];
    bit                inter_set  [INTER_DEPTH];

    t_out_word pending_results[$];
    t_out_word due_res;
    t_dir_row  dir_tab[$];

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int n_mismatch = 0;
    int n_checked  = 0;
    int n_loads    = 0;
    int n_ops      = 0;
    int n_reads    = 0;
    int n_ignored  = 0;
    int n_useful   = 0;

    xor_schedule_packet_engine u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // store predictor: applies one word and returns the result it causes
    function automatic t_out_word apply_engine_word(input t_in_word w);
        t_out_word         r;
        int                base_s;
        int                base_d;
        int                src_lim;
        int                dst_lim;
        bit                src_inter;
        bit                dst_parity;
        bit                xor_in;
        logic [DATA_W-1:0] src_w;
        r.read_value = '0;
        r.done_kind  = w.command;
        base_s = int'(w.src_packet) * PACKET_WORDS;
        base_d = int'(w.dst_packet) * PACKET_WORDS;
        case (w.command)
            CMD_LOAD: begin
                if (w.dst_packet < DATA_PACKETS && w.word_offset < PACKET_WORDS) begin
                    data_mem[base_d + int'(w.word_offset)] = w.word_value;
                    data_set[base_d + int'(w.word_offset)] = 1'b1;
                end
            end
            CMD_READ: begin
                if (w.dst_packet < PARITY_PACKETS && w.word_offset < PACKET_WORDS)
                    r.read_value = parity_mem[base_d + int'(w.word_offset)];
            end
            CMD_RUN: begin
                if (w.op_code <= OP_XOR_D2I) begin
                    src_inter  = (w.op_code == OP_COPY_I2P) || (w.op_code == OP_XOR_I2P);
                    dst_parity = (w.op_code <= OP_XOR_I2P);
                    xor_in     = (w.op_code == OP_XOR_D2P) || (w.op_code == OP_XOR_I2P)
                                 || (w.op_code == OP_XOR_D2I);
                    src_lim = src_inter ? INTER_PACKETS : DATA_PACKETS;
                    dst_lim = dst_parity ? PARITY_PACKETS : INTER_PACKETS;
                    if (w.src_packet < src_lim && w.dst_packet < dst_lim) begin
                        for (int k = 0; k < PACKET_WORDS; k++) begin
                            src_w = src_inter ? inter_mem[base_s + k] : data_mem[base_s + k];
                            if (dst_parity) begin
                                parity_mem[base_d + k] = xor_in ? parity_mem[base_d + k] ^ src_w
                                                                : src_w;
                                parity_set[base_d + k] = 1'b1;
                            end else begin
                                inter_mem[base_d + k] = xor_in ? inter_mem[base_d + k] ^ src_w
                                                               : src_w;
                                inter_set[base_d + k] = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // a packet may be used as an operand only when every word of it was written
    function automatic bit packet_written(input t_store st, input int p);
        bit ok;
        ok = 1'b1;
        for (int k = 0; k < PACKET_WORDS; k++) begin
            case (st)
                ST_DATA:   ok = ok && data_set[p * PACKET_WORDS + k];
                ST_PARITY: ok = ok && parity_set[p * PACKET_WORDS + k];
                default:   ok = ok && inter_set[p * PACKET_WORDS + k];
            endcase
        end
        return ok;
    endfunction

    // random fully written packet of a store, -1 when there is none yet
    function automatic int pick_written(input t_store st);
        int pool[$];
        int lim;
        lim = (st == ST_DATA) ? DATA_PACKETS : (st == ST_PARITY) ? PARITY_PACKETS
                                                                 : INTER_PACKETS;
        for (int p = 0; p < lim; p++)
            if (packet_written(st, p))
                pool.insert(pool.size(), p);
        if (pool.size() == 0)
            return -1;
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_word rand_in_word();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return t_in_word'(bits[$bits(t_in_word)-1:0]);
    endfunction

    function automatic t_dir_row row(input bit fill, input logic [CMD_W-1:0] cmd,
                                     input logic [OP_W-1:0] op, input logic [PKT_W-1:0] src,
                                     input logic [PKT_W-1:0] dst, input logic [OFS_W-1:0] ofs,
                                     input logic [DATA_W-1:0] val, input bit typed,
                                     input logic [DATA_W-1:0] want_val);
        t_dir_row r;
        r.fill     = fill;
        r.cmd      = cmd;
        r.op       = op;
        r.src      = src;
        r.dst      = dst;
        r.ofs      = ofs;
        r.val      = val;
        r.typed    = typed;
        r.want_val = want_val;
        return r;
    endfunction

    // offer one word, hold it until accepted, then log what it should produce
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        t_out_word predicted;
        while (!calm && $urandom_range(99) < 6) begin
            @(negedge clk);
            in_valid = 1'b0;
            in_data  = rand_in_word();
            @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_engine_word(w);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        case (w.command)
            CMD_LOAD: n_loads++;
            CMD_RUN:  n_ops++;
            CMD_READ: n_reads++;
            default:  ;
        endcase
        if (w.command == CMD_UNUSED || (w.command == CMD_RUN && w.op_code > OP_XOR_D2I))
            n_ignored++;
        else
            n_useful++;
    endtask

    task automatic send_load(input int p, input int ofs);
        t_in_word w;
        w = rand_in_word();
        w.command     = CMD_LOAD;
        w.dst_packet  = PKT_W'(p);
        w.word_offset = OFS_W'(ofs);
        w.word_value  = rand_value();
        send_word(w, 1'b0, '0);
    endtask

    // schedule op on written operands; falls back to a load while stores are empty
    task automatic send_schedule_op();
        t_in_word w;
        int       s;
        int       d;
        w = rand_in_word();
        w.command = CMD_RUN;
        w.op_code = OP_W'($urandom_range(7));
        s = 0;
        d = 0;
        if (w.op_code <= OP_XOR_D2I) begin
            s = pick_written((w.op_code == OP_COPY_I2P || w.op_code == OP_XOR_I2P)
                             ? ST_INTER : ST_DATA);
            case (w.op_code)
                OP_XOR_D2P, OP_XOR_I2P: d = pick_written(ST_PARITY);
                OP_XOR_D2I:             d = pick_written(ST_INTER);
                default:                d = int'($urandom_range((1 << PKT_W) - 1));
            endcase
            w.src_packet = PKT_W'(s);
            w.dst_packet = PKT_W'(d);
        end
        if (s < 0 || d < 0)
            send_load(int'($urandom_range(DATA_PACKETS - 1)),
                      int'($urandom_range(PACKET_WORDS - 1)));
        else
            send_word(w, 1'b0, '0);
    endtask

    task automatic send_parity_read();
        t_in_word w;
        int       p;
        p = pick_written(ST_PARITY);
        if (p < 0) begin
            send_schedule_op();
        end else begin
            w = rand_in_word();
            w.command     = CMD_READ;
            w.dst_packet  = PKT_W'(p);
            w.word_offset = OFS_W'($urandom_range(PACKET_WORDS - 1));
            send_word(w, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: read_value %h done_kind %0d", $time,
                         out_data.read_value, out_data.done_kind);
                n_mismatch++;
            end else begin
                due_res = pending_results.pop_front();
                n_checked++;
                if (out_data.read_value !== due_res.read_value) begin
                    $display("%0t read_value mismatch: expected %h, got %h", $time,
                             due_res.read_value, out_data.read_value);
                    n_mismatch++;
                end
                if (out_data.done_kind !== due_res.done_kind) begin
                    $display("%0t done_kind mismatch: expected %0d, got %0d", $time,
                             due_res.done_kind, out_data.done_kind);
                    n_mismatch++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall = 1'b1;
            end else begin
                out_stall = !calm && ($urandom_range(99) < 6);
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial begin
        t_dir_row  r;
        t_in_word  w;
        t_out_word typed_res;
        int        roll;
        int        p;
        bit        hold_done;
        bit        drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;

        // directed table: all-ones / all-zero words pass through every operation
        dir_tab.insert(dir_tab.size(), row(1, CMD_LOAD, OP_COPY_D2P, 0, 63, 0, '1, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_LOAD, OP_COPY_D2P, 0, 0, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_LOAD, OP_COPY_D2P, 0, 0, 15, '1, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_COPY_D2P, 63, 0, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_COPY_D2P, 0, 0, 0, '0, 1, '1));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_COPY_D2P, 0, 0, 15, '0, 1, '0));
        // xor of a packet with itself clears it
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_XOR_D2P, 63, 0, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_COPY_D2P, 0, 0, 0, '0, 1, '0));
        // through the intermediate store
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_COPY_D2I, 63, 63, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_XOR_D2I, 63, 63, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_COPY_I2P, 63, 63, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_COPY_D2P, 0, 63, 14, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_COPY_D2I, 63, 0, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_XOR_I2P, 0, 0, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_COPY_D2P, 0, 0, 14, '0, 1, '1));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_COPY_D2P, 0, 0, 1, '0, 1, '0));
        // unused op codes leave the stores alone
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_NOP_6, 0, 0, 0, '0, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_NOP_7, 63, 63, 15, '1, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_NOP_7, 63, 0, 14, '1, 1, '1));
        // unused command answers zero and echoes itself
        dir_tab.insert(dir_tab.size(), row(0, CMD_UNUSED, OP_NOP_7, 63, 63, 15, '1, 1, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_UNUSED, OP_COPY_D2P, 0, 0, 0, '0, 1, '0));
        // mixed chain left to the predictor
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_XOR_D2I, 63, 0, 0, '0, 0, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_RUN, OP_XOR_I2P, 0, 63, 0, '0, 0, '0));
        dir_tab.insert(dir_tab.size(), row(0, CMD_READ, OP_COPY_D2P, 0, 63, 2, '1, 0, '0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            r = dir_tab[i];
            w = '0;
            w.command     = r.cmd;
            w.op_code     = r.op;
            w.src_packet  = r.src;
            w.dst_packet  = r.dst;
            w.word_offset = r.ofs;
            w.word_value  = r.val;
            typed_res.read_value = r.want_val;
            typed_res.done_kind  = r.cmd;
            if (r.fill) begin
                // even words take the pattern, odd words its inverse
                for (int k = 0; k < PACKET_WORDS; k++) begin
                    w.word_offset = OFS_W'(k);
                    w.word_value  = k[0] ? ~r.val : r.val;
                    send_word(w, r.typed, typed_res);
                end
            end else begin
                send_word(w, r.typed, typed_res);
            end
        end

        // random traffic: whole-packet fills feed schedule ops and parity reads
        while (n_useful < RANDOM_WORDS) begin
            if (n_useful >= 150 && !hold_done) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (n_useful >= 380 && !drain_done) begin
                drain_done = 1'b1;
                @(negedge clk);
                in_valid = 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            calm = (n_useful >= 240 && n_useful < 330);
            roll = int'($urandom_range(99));
            if (roll < 20) begin
                p = int'($urandom_range(DATA_PACKETS - 1));
                for (int k = 0; k < PACKET_WORDS; k++)
                    send_load(p, k);
            end else if (roll < 58) begin
                send_schedule_op();
            end else if (roll < 86) begin
                send_parity_read();
            end else if (roll < 95) begin
                send_load(int'($urandom_range(DATA_PACKETS - 1)),
                          int'($urandom_range(PACKET_WORDS - 1)));
            end else begin
                w = rand_in_word();
                w.command = CMD_UNUSED;
                send_word(w, 1'b0, '0);
            end
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d data loads, %0d schedule ops, %0d parity reads (%0d ignored)",
                 n_loads, n_ops, n_reads, n_ignored);
        $display("%0d results checked, %0d mismatches", n_checked, n_mismatch);
        if (n_mismatch == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/xsp_pkg.sv
hw/rtl/xsp_ram.sv
hw/rtl/xor_schedule_packet_engine.sv
hw/rtl/xsp_checker.sv
dv/testbench.sv
